@@ rtl/rtdlin_pkg.sv @@
// ----------------------------------------------------------------------------
// rtdlin_pkg
// Shared widths, codes and types for the RTD divider temperature linearizer.
// ----------------------------------------------------------------------------
package rtdlin_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 16;
  localparam int ADC_W       = 10;
  localparam int RES_W       = 16;
  localparam int USED_W      = 8;
  localparam int FRAC_W      = 8;
  localparam int TEMP_W      = IDX_W + FRAC_W;
  localparam int STATUS_W    = 2;
  localparam int SCALE_W     = 7;
  localparam int PROD_W      = RES_W + ADC_W;
  localparam int NUM_W       = PROD_W + SCALE_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // ohms to hundredths of an ohm
  localparam logic [SCALE_W-1:0]   SCALE_HUNDREDTHS = 7'd100;
  localparam logic [ADC_W-1:0]     ADC_FULL_SCALE   = 10'd1023;
  localparam logic [RES_W-1:0]     DIVIDER_RESET    = 16'd217;
  localparam logic [USED_W-1:0]    TABLE_USED_RESET = 8'd80;

  localparam logic [DIV_CNT_W-1:0] ITERS_OHMS   = DIV_CNT_W'(NUM_W);
  localparam logic [DIV_CNT_W-1:0] ITERS_INTERP = DIV_CNT_W'(FRAC_W);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RESISTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_USED       = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_WALK,
    S_INT_START,
    S_INT_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [ENTRY_W-1:0]   rem0;
    logic [NUM_W-1:0]     dvd;
    logic [ENTRY_W-1:0]   divisor;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/rtdlin_table_ram.sv @@
// ----------------------------------------------------------------------------
// rtdlin_table_ram
// Resistance table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtdlin_table_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [rtdlin_pkg::IDX_W-1:0]    waddr,
  input  logic [rtdlin_pkg::ENTRY_W-1:0]  wdata,
  input  logic [rtdlin_pkg::IDX_W-1:0]    raddr,
  output logic [rtdlin_pkg::ENTRY_W-1:0]  rdata
);

  logic [rtdlin_pkg::ENTRY_W-1:0] mem [rtdlin_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rtdlin_divider.sv @@
// ----------------------------------------------------------------------------
// rtdlin_divider
// Restoring divider, one quotient bit per cycle. Shared by the resistance
// calculation and the interpolation step.
// ----------------------------------------------------------------------------
module rtdlin_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtdlin_pkg::div_req_t  req,
  output rtdlin_pkg::div_rsp_t  rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [rtdlin_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [rtdlin_pkg::ENTRY_W-1:0]      rem_r;
  logic [rtdlin_pkg::ENTRY_W-1:0]      dsr_r;
  logic [rtdlin_pkg::NUM_W-1:0]        dvd_r;
  logic [rtdlin_pkg::NUM_W-1:0]        quot_r;

  logic [rtdlin_pkg::ENTRY_W:0]        trial;
  logic [rtdlin_pkg::ENTRY_W:0]        diff;
  logic                                ge;

  // partial remainder stays below the divisor, so it fits ENTRY_W bits
  assign trial = {rem_r, dvd_r[rtdlin_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == rtdlin_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r  <= req.iters;
      rem_r  <= req.rem0;
      dsr_r  <= req.divisor;
      dvd_r  <= req.dvd;
      quot_r <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      rem_r  <= ge ? diff[rtdlin_pkg::ENTRY_W-1:0] : trial[rtdlin_pkg::ENTRY_W-1:0];
      dvd_r  <= {dvd_r[rtdlin_pkg::NUM_W-2:0], 1'b0};
      quot_r <= {quot_r[rtdlin_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ rtl/rtd_divider_temperature_linearizer_top.sv @@
// ----------------------------------------------------------------------------
// rtd_divider_temperature_linearizer_top
// ADC code to sensor resistance, then table inversion with linear
// interpolation to degrees with 8 fraction bits.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_stall  | operation, entry_index,
//              |           |                    | entry_value, adc_code
//   out_       | output    | out_valid/out_stall| status, temperature, resistance
//   cfg_       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load request writes one table entry. A convert request at full scale
// goes straight to the result; otherwise the 33-step divide runs, then the
// walk steps past k table entries (k 0 to 127, one table read per cycle) and
// ends on a match or out of range, or interpolates with the 8-step divide on
// the shared divider.
// Synchronous active-low reset; the table holds no valid state after it.
// in_stall is high while a conversion is in progress; the result register
// lets the next request in while a finished result is held by out_stall.
// ----------------------------------------------------------------------------
module rtd_divider_temperature_linearizer_top (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [rtdlin_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [rtdlin_pkg::ENTRY_W-1:0]      in_entry_value,
  input  logic [rtdlin_pkg::ADC_W-1:0]        in_adc_code,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rtdlin_pkg::STATUS_W-1:0]     out_status,
  output logic [rtdlin_pkg::TEMP_W-1:0]       out_temperature,
  output logic [rtdlin_pkg::ENTRY_W-1:0]      out_resistance,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtdlin_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtdlin_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rtdlin_pkg::state_t                 state_r, state_nxt;

  logic [rtdlin_pkg::RES_W-1:0]       div_res_r;
  logic [rtdlin_pkg::USED_W-1:0]      table_used_r;

  logic [rtdlin_pkg::ADC_W-1:0]       code_r, code_nxt;
  logic [rtdlin_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [rtdlin_pkg::NUM_W-1:0]       ohms_r, ohms_nxt;
  logic [rtdlin_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [rtdlin_pkg::ENTRY_W-1:0]     prev_r, prev_nxt;
  logic [rtdlin_pkg::ENTRY_W-1:0]     hi_r, hi_nxt;
  logic [rtdlin_pkg::ENTRY_W-1:0]     top_r, top_nxt;
  logic [rtdlin_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [rtdlin_pkg::TEMP_W-1:0]      temp_r, temp_nxt;
  logic [rtdlin_pkg::ENTRY_W-1:0]     res_r, res_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [rtdlin_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [rtdlin_pkg::TEMP_W-1:0]      out_temp_r, out_temp_nxt;
  logic [rtdlin_pkg::ENTRY_W-1:0]     out_res_r, out_res_nxt;

  logic [rtdlin_pkg::IDX_W-1:0]       last_idx;
  logic                               ram_we;
  logic [rtdlin_pkg::IDX_W-1:0]       ram_raddr;
  logic [rtdlin_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [rtdlin_pkg::NUM_W-1:0]       entry_wide;
  logic [rtdlin_pkg::NUM_W-1:0]       top_wide;
  logic                               in_take;

  rtdlin_pkg::div_req_t               div_req;
  rtdlin_pkg::div_rsp_t               div_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_res_r    <= rtdlin_pkg::DIVIDER_RESET;
      table_used_r <= rtdlin_pkg::TABLE_USED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtdlin_pkg::CFG_DIVIDER_RESISTOR: div_res_r    <= cfg_data;
        rtdlin_pkg::CFG_TABLE_USED:       table_used_r <= cfg_data[rtdlin_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  // table_used of 0 acts as 1, above the depth acts as the depth
  always_comb begin
    if (table_used_r == '0) begin
      last_idx = '0;
    end else if (int'(table_used_r) > rtdlin_pkg::TABLE_DEPTH) begin
      last_idx = rtdlin_pkg::IDX_W'(rtdlin_pkg::TABLE_DEPTH - 1);
    end else begin
      last_idx = rtdlin_pkg::IDX_W'(table_used_r - 1'b1);
    end
  end

  // ----------------------------------------------------------------- table
  assign in_stall = (state_r != rtdlin_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign ram_we   = in_take && (in_operation == rtdlin_pkg::OP_LOAD);
  // look one entry ahead during the walk so a compare completes every cycle;
  // the last entry is read while the divide runs, entry 0 as it finishes
  assign ram_raddr  = (state_r == rtdlin_pkg::S_WALK) ? idx_r + 1'b1
                      : (state_r == rtdlin_pkg::S_DIV_WAIT && !div_rsp.done) ? last_idx
                      : '0;
  assign entry_wide = rtdlin_pkg::NUM_W'(ram_rdata);
  assign top_wide   = rtdlin_pkg::NUM_W'(top_r);

  rtdlin_table_ram u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index),
    .wdata (in_entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rtdlin_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ----------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtdlin_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    prod_r       <= prod_nxt;
    ohms_r       <= ohms_nxt;
    idx_r        <= idx_nxt;
    prev_r       <= prev_nxt;
    hi_r         <= hi_nxt;
    top_r        <= top_nxt;
    status_r     <= status_nxt;
    temp_r       <= temp_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_temp_r   <= out_temp_nxt;
    out_res_r    <= out_res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    prod_nxt       = prod_r;
    ohms_nxt       = ohms_r;
    idx_nxt        = idx_r;
    prev_nxt       = prev_r;
    hi_nxt         = hi_r;
    top_nxt        = top_r;
    status_nxt     = status_r;
    temp_nxt       = temp_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_temp_nxt   = out_temp_r;
    out_res_nxt    = out_res_r;
    div_req        = '0;

    unique case (state_r)
      rtdlin_pkg::S_IDLE: begin
        if (in_take && in_operation == rtdlin_pkg::OP_CONVERT) begin
          code_nxt = in_adc_code;
          if (in_adc_code >= rtdlin_pkg::ADC_FULL_SCALE) begin
            status_nxt = rtdlin_pkg::ST_ABOVE;
            temp_nxt   = '0;
            res_nxt    = '1;
            state_nxt  = rtdlin_pkg::S_DONE;
          end else begin
            state_nxt  = rtdlin_pkg::S_MUL;
          end
        end
      end
      rtdlin_pkg::S_MUL: begin
        prod_nxt  = rtdlin_pkg::PROD_W'(div_res_r) * rtdlin_pkg::PROD_W'(code_r);
        state_nxt = rtdlin_pkg::S_DIV_START;
      end
      rtdlin_pkg::S_DIV_START: begin
        div_req.start   = 1'b1;
        div_req.rem0    = '0;
        div_req.dvd     = rtdlin_pkg::NUM_W'(prod_r)
                          * rtdlin_pkg::NUM_W'(rtdlin_pkg::SCALE_HUNDREDTHS);
        div_req.divisor = rtdlin_pkg::ENTRY_W'(rtdlin_pkg::ADC_FULL_SCALE - code_r);
        div_req.iters   = rtdlin_pkg::ITERS_OHMS;
        state_nxt       = rtdlin_pkg::S_DIV_WAIT;
      end
      rtdlin_pkg::S_DIV_WAIT: begin
        // last entry arrives now; table entry 0 is being read this cycle
        if (div_rsp.done) begin
          ohms_nxt  = div_rsp.quot;
          res_nxt   = (|div_rsp.quot[rtdlin_pkg::NUM_W-1:rtdlin_pkg::ENTRY_W]) ? '1
                      : div_rsp.quot[rtdlin_pkg::ENTRY_W-1:0];
          top_nxt   = ram_rdata;
          idx_nxt   = '0;
          state_nxt = rtdlin_pkg::S_WALK;
        end
      end
      rtdlin_pkg::S_WALK: begin
        // range tests against the first and last entries hold whether or not
        // the table increases
        if (idx_r == '0 && ohms_r < entry_wide) begin
          status_nxt = rtdlin_pkg::ST_BELOW;
          temp_nxt   = '0;
          state_nxt  = rtdlin_pkg::S_DONE;
        end else if (ohms_r > top_wide) begin
          status_nxt = rtdlin_pkg::ST_ABOVE;
          temp_nxt   = '0;
          state_nxt  = rtdlin_pkg::S_DONE;
        end else if (idx_r < last_idx && ohms_r > entry_wide) begin
          prev_nxt = ram_rdata;
          idx_nxt  = idx_r + 1'b1;
        end else if (ohms_r == entry_wide) begin
          status_nxt = rtdlin_pkg::ST_OK;
          temp_nxt   = {idx_r, rtdlin_pkg::FRAC_W'(0)};
          state_nxt  = rtdlin_pkg::S_DONE;
        end else begin
          // strictly between prev and this entry, and idx is at least 1
          hi_nxt    = ram_rdata;
          state_nxt = rtdlin_pkg::S_INT_START;
        end
      end
      rtdlin_pkg::S_INT_START: begin
        // remainder starts at ohms - lo, which is below hi - lo
        div_req.start   = 1'b1;
        div_req.rem0    = ohms_r[rtdlin_pkg::ENTRY_W-1:0] - prev_r;
        div_req.dvd     = '0;
        div_req.divisor = hi_r - prev_r;
        div_req.iters   = rtdlin_pkg::ITERS_INTERP;
        state_nxt       = rtdlin_pkg::S_INT_WAIT;
      end
      rtdlin_pkg::S_INT_WAIT: begin
        if (div_rsp.done) begin
          status_nxt = rtdlin_pkg::ST_OK;
          temp_nxt   = {idx_r - 1'b1, div_rsp.quot[rtdlin_pkg::FRAC_W-1:0]};
          state_nxt  = rtdlin_pkg::S_DONE;
        end
      end
      rtdlin_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_temp_nxt   = temp_r;
          out_res_nxt    = res_r;
          state_nxt      = rtdlin_pkg::S_IDLE;
        end
      end
      default: state_nxt = rtdlin_pkg::S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_temperature = out_temp_r;
  assign out_resistance  = out_res_r;

  // ------------------------------------------------------------ assertions
  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == rtdlin_pkg::S_DIV_WAIT || state_r == rtdlin_pkg::S_INT_WAIT))
    else $error("divider finished outside a wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rtdlin_pkg::S_DONE)
    else $error("result appeared without a finished conversion");

  a_div_idle_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtdlin_pkg::S_IDLE |-> !div_rsp.busy)
    else $error("divider busy while accepting requests");

  a_temp_zero_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtdlin_pkg::S_DONE && status_r != rtdlin_pkg::ST_OK) |-> temp_r == '0)
    else $error("temperature nonzero with out-of-range status");

endmodule
